// ----- hdl/hwt_pkg.sv -----
package hwt_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_JITTER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_X_MODE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_Y_MODE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE_DIR  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RNG_SEED     = 3'd7;

  localparam logic [10:0] RST_FRAME_WIDTH  = 11'd320;
  localparam logic [10:0] RST_FRAME_HEIGHT = 11'd200;
  localparam logic [8:0]  RST_BASE_SPEED   = 9'd100;
  localparam logic [6:0]  RST_SPEED_JITTER = 7'd70;
  localparam logic        RST_SLOW_X_MODE  = 1'b0;
  localparam logic        RST_SLOW_Y_MODE  = 1'b1;
  localparam logic        RST_REVERSE_DIR  = 1'b0;
  localparam logic [31:0] RST_RNG_SEED     = 32'd1;

  localparam logic [31:0] LCG_MUL = 32'd1664525;
  localparam logic [31:0] LCG_INC = 32'd1013904223;

  localparam int SLOW_GAIN = 2500;
  localparam int ROT_DIV   = 700;
  localparam int PCT_DIV   = 100;
  localparam int CTR_OFS   = 10;
  localparam int SPEED_MIN = 30;
  localparam int SPEED_MAX = 300;
  localparam int JIT_MAX   = 100;

  // floor(n/3) = (n * 43691) >> 17, exact for n below 2^16
  localparam int THIRD_MUL   = 43691;
  localparam int THIRD_SHIFT = 17;

  typedef struct packed {
    logic       restart;
    logic [9:0] pixel_x;
    logic [9:0] pixel_y;
  } in_word_t;

  typedef struct packed {
    logic [19:0] source_index;
    logic [9:0]  source_col;
    logic [9:0]  source_row;
  } out_word_t;

endpackage

// ----- hdl/hwt_div.sv -----
module hwt_div #(
  parameter int DVW = 24
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [$clog2(DVW+1)-1:0]   len,
  input  logic [DVW-1:0]             dividend,
  input  logic [DVW-1:0]             divisor,
  output logic                       done,
  output logic [DVW-1:0]             quot,
  output logic [DVW-1:0]             rem
);

  localparam int LW = $clog2(DVW+1);

  logic          busy_r;
  logic          done_r;
  logic [LW-1:0] cnt_r;
  logic [DVW-1:0] num_r;
  logic [DVW-1:0] rem_r;
  logic [DVW-1:0] quot_r;
  logic [DVW-1:0] dvs_r;

  logic [DVW:0]   trial;
  logic           ge;
  logic [DVW-1:0] rem_nxt;

  // restoring divider, one quotient bit per cycle, dividend left-aligned
  assign trial   = {rem_r, num_r[DVW-1]};
  assign ge      = (trial >= {1'b0, dvs_r});
  assign rem_nxt = ge ? DVW'(trial - {1'b0, dvs_r}) : trial[DVW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= len;
        num_r  <= DVW'(dividend << (LW'(DVW) - len));
        rem_r  <= '0;
        quot_r <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        num_r  <= {num_r[DVW-2:0], 1'b0};
        rem_r  <= rem_nxt;
        quot_r <= {quot_r[DVW-2:0], ge};
        cnt_r  <= cnt_r - LW'(1);
        if (cnt_r == LW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < dvs_r))
    else $error("divider remainder not below divisor");

  a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r != '0))
    else $error("divider busy with no bits left");

endmodule

// ----- hdl/hurricane_warp_table_core.sv -----
// Per word, divisions run on the shared one-bit-per-cycle divider:
// two always (rotation offsets /700), two always (modulo by width and height),
// one more with jitter (/100), one or two more in slow modes. Five steps do no
// division: GEOM, SQ, PREP, MUL and IDX.
// One word in flight: no new word is taken until the last result is registered, later if a result waits.
// Reset (rst_n, synchronous): registers to default values, generator state to 1.
module hurricane_warp_table_core #(
  parameter int MAX_WIDTH  = hwt_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = hwt_pkg::DEF_MAX_HEIGHT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  hwt_pkg::in_word_t                 in_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output hwt_pkg::out_word_t                out_word,
  input  logic                              cfg_we,
  input  logic [hwt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hwt_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int SW0   = (WW > HW) ? WW : HW;
  localparam int SW    = ((SW0 > 11) ? SW0 : 11) + 1;  // signed offset width
  localparam int MW    = SW - 1;                       // offset magnitude width
  localparam int DVW   = 2 * SW;
  localparam int LW    = $clog2(DVW + 1);
  localparam int PLEN  = 16;                           // speed product bits
  localparam int SLEN  = SW + 11;                      // offset * 2500 bits
  localparam int QLEN  = SW + 9;                       // offset * speed bits
  localparam int MLEN  = SW + 1;                       // wrapped coordinate bits

  typedef enum logic [3:0] {
    S_IDLE, S_GEOM, S_SQ, S_PREP, S_SPD, S_NDX, S_NDY,
    S_MUL, S_QX, S_QY, S_MX, S_MY, S_IDX
  } state_t;

  state_t state_r, state_nxt, post_sp;

  // configuration registers
  logic [10:0] fw_r, fh_r;
  logic [8:0]  speed_r;
  logic [6:0]  jit_r;
  logic        slowx_r, slowy_r, rev_r;
  logic [31:0] seed_r;

  // datapath registers
  logic [31:0]          lcg_r;
  logic [9:0]           x_r, y_r;
  logic [MW-1:0]        adx_r, ady_r;
  logic                 sdx_r, sdy_r;
  logic [6:0]           rdraw_r;
  logic [2*MW-1:0]      dx2_r, dy2_r;
  logic [SLEN-1:0]      dx2500_r, dy2500_r;
  logic [DVW-1:0]       dsq_r;
  logic [PLEN-1:0]      prod_r;
  logic [9:0]           sp_r;
  logic [QLEN-1:0]      qx_num_r, qy_num_r;
  logic signed [SW+1:0] mx_r, my_r;
  logic [WW-1:0]        col_r;
  logic [HW-1:0]        row_r;
  logic                 div_go_r;
  logic                 out_valid_r;
  hwt_pkg::out_word_t   out_word_r;

  // clamped settings and frame geometry
  logic [WW-1:0]         w_c;
  logic [HW-1:0]         h_c;
  logic [8:0]            speed_c;
  logic [6:0]            jit_c;
  logic [WW+16:0]        w_third_prod;
  logic [WW-1:0]         cx;
  logic [23:0]           j_third_prod;
  logic [5:0]            j3;
  logic signed [SW-1:0]  cy_s, dx_s, dy_s;
  logic [SW-1:0]         dx_abs, dy_abs;
  logic [39:0]           draw_prod;
  logic [7:0]            k_pct;
  logic [16:0]           sk_prod;
  logic [SW+1:0]         mx_abs, my_abs;
  logic [SW-1:0]         q_s;
  logic [WW-1:0]         rem_w;
  logic [HW-1:0]         rem_h;
  logic [HW+WW:0]        idx_full;
  logic                  out_free;
  logic                  div_enter;

  logic [DVW-1:0] div_dvd, div_dvs;
  logic [LW-1:0]  div_len;
  logic           div_done;
  logic [DVW-1:0] div_quot, div_rem;

  always_comb begin
    if (fw_r == '0) begin
      w_c = WW'(1);
    end else if (32'(fw_r) > 32'(MAX_WIDTH)) begin
      w_c = WW'(MAX_WIDTH);
    end else begin
      w_c = WW'(fw_r);
    end
    if (fh_r == '0) begin
      h_c = HW'(1);
    end else if (32'(fh_r) > 32'(MAX_HEIGHT)) begin
      h_c = HW'(MAX_HEIGHT);
    end else begin
      h_c = HW'(fh_r);
    end
    if (32'(speed_r) < 32'(hwt_pkg::SPEED_MIN)) begin
      speed_c = 9'(hwt_pkg::SPEED_MIN);
    end else if (32'(speed_r) > 32'(hwt_pkg::SPEED_MAX)) begin
      speed_c = 9'(hwt_pkg::SPEED_MAX);
    end else begin
      speed_c = speed_r;
    end
    if (32'(jit_r) > 32'(hwt_pkg::JIT_MAX)) begin
      jit_c = 7'(hwt_pkg::JIT_MAX);
    end else begin
      jit_c = jit_r;
    end
  end

  assign w_third_prod = (WW+17)'(w_c) * (WW+17)'(hwt_pkg::THIRD_MUL);
  assign cx           = w_third_prod[hwt_pkg::THIRD_SHIFT +: WW];
  assign j_third_prod = 24'(jit_c) * 24'(hwt_pkg::THIRD_MUL);
  assign j3           = j_third_prod[hwt_pkg::THIRD_SHIFT +: 6];

  assign cy_s   = $signed(SW'(h_c >> 1)) - $signed(SW'(hwt_pkg::CTR_OFS));
  assign dx_s   = $signed(SW'(x_r)) - $signed(SW'(cx));
  assign dy_s   = $signed(SW'(y_r)) - cy_s;
  assign dx_abs = dx_s[SW-1] ? SW'(-dx_s) : SW'(dx_s);
  assign dy_abs = dy_s[SW-1] ? SW'(-dy_s) : SW'(dy_s);

  // r = (lcg * (J + 1)) >> 32
  assign draw_prod = 40'(lcg_r) * 40'(8'(jit_c) + 8'd1);
  assign k_pct     = 8'(hwt_pkg::PCT_DIV) + 8'(rdraw_r) - 8'(j3);
  assign sk_prod   = 17'(speed_c) * 17'(k_pct);

  assign mx_abs = mx_r[SW+1] ? (SW+2)'(-mx_r) : (SW+2)'(mx_r);
  assign my_abs = my_r[SW+1] ? (SW+2)'(-my_r) : (SW+2)'(my_r);
  assign q_s    = div_quot[SW-1:0];
  assign rem_w  = div_rem[WW-1:0];
  assign rem_h  = div_rem[HW-1:0];

  assign idx_full = (HW+WW+1)'(row_r) * (HW+WW+1)'(w_c) + (HW+WW+1)'(col_r);
  assign out_free = !out_valid_r || !out_stall;

  // shared divider operands
  always_comb begin
    case (state_r)
      S_SPD: begin
        div_dvd = DVW'(prod_r);
        div_dvs = DVW'(hwt_pkg::PCT_DIV);
        div_len = LW'(PLEN);
      end
      S_NDX: begin
        div_dvd = DVW'(dx2500_r);
        div_dvs = dsq_r;
        div_len = LW'(SLEN);
      end
      S_NDY: begin
        div_dvd = DVW'(dy2500_r);
        div_dvs = dsq_r;
        div_len = LW'(SLEN);
      end
      S_QX: begin
        div_dvd = DVW'(qx_num_r);
        div_dvs = DVW'(hwt_pkg::ROT_DIV);
        div_len = LW'(QLEN);
      end
      S_QY: begin
        div_dvd = DVW'(qy_num_r);
        div_dvs = DVW'(hwt_pkg::ROT_DIV);
        div_len = LW'(QLEN);
      end
      S_MX: begin
        div_dvd = DVW'(mx_abs[MLEN-1:0]);
        div_dvs = DVW'(w_c);
        div_len = LW'(MLEN);
      end
      S_MY: begin
        div_dvd = DVW'(my_abs[MLEN-1:0]);
        div_dvs = DVW'(h_c);
        div_len = LW'(MLEN);
      end
      default: begin
        div_dvd = '0;
        div_dvs = DVW'(1);
        div_len = LW'(1);
      end
    endcase
  end

  hwt_div #(
    .DVW(DVW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go_r),
    .len      (div_len),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_comb begin
    if (slowy_r) begin
      post_sp = S_NDX;
    end else if (slowx_r) begin
      post_sp = S_NDY;
    end else begin
      post_sp = S_MUL;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_GEOM;
      S_GEOM: state_nxt = S_SQ;
      S_SQ:   state_nxt = S_PREP;
      S_PREP: state_nxt = (jit_c != '0) ? S_SPD : post_sp;
      S_SPD:  if (div_done) state_nxt = post_sp;
      S_NDX:  if (div_done) state_nxt = slowx_r ? S_NDY : S_MUL;
      S_NDY:  if (div_done) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_QX;
      S_QX:   if (div_done) state_nxt = S_QY;
      S_QY:   if (div_done) state_nxt = S_MX;
      S_MX:   if (div_done) state_nxt = S_MY;
      S_MY:   if (div_done) state_nxt = S_IDX;
      S_IDX:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign div_enter = (state_nxt != state_r) &&
                     (state_nxt == S_SPD || state_nxt == S_NDX || state_nxt == S_NDY ||
                      state_nxt == S_QX  || state_nxt == S_QY  ||
                      state_nxt == S_MX  || state_nxt == S_MY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r    <= hwt_pkg::RST_FRAME_WIDTH;
      fh_r    <= hwt_pkg::RST_FRAME_HEIGHT;
      speed_r <= hwt_pkg::RST_BASE_SPEED;
      jit_r   <= hwt_pkg::RST_SPEED_JITTER;
      slowx_r <= hwt_pkg::RST_SLOW_X_MODE;
      slowy_r <= hwt_pkg::RST_SLOW_Y_MODE;
      rev_r   <= hwt_pkg::RST_REVERSE_DIR;
      seed_r  <= hwt_pkg::RST_RNG_SEED;
    end else if (cfg_we) begin
      case (cfg_index)
        hwt_pkg::REG_FRAME_WIDTH:  fw_r    <= cfg_wdata[10:0];
        hwt_pkg::REG_FRAME_HEIGHT: fh_r    <= cfg_wdata[10:0];
        hwt_pkg::REG_BASE_SPEED:   speed_r <= cfg_wdata[8:0];
        hwt_pkg::REG_SPEED_JITTER: jit_r   <= cfg_wdata[6:0];
        hwt_pkg::REG_SLOW_X_MODE:  slowx_r <= cfg_wdata[0];
        hwt_pkg::REG_SLOW_Y_MODE:  slowy_r <= cfg_wdata[0];
        hwt_pkg::REG_REVERSE_DIR:  rev_r   <= cfg_wdata[0];
        hwt_pkg::REG_RNG_SEED:     seed_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
      lcg_r       <= 32'd1;
    end else begin
      state_r  <= state_nxt;
      div_go_r <= div_enter;
      if (state_r == S_IDX && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            x_r <= in_word.pixel_x;
            y_r <= in_word.pixel_y;
            if (in_word.restart) lcg_r <= (seed_r == '0) ? 32'd1 : seed_r;
          end
        end
        S_GEOM: begin
          adx_r <= dx_abs[MW-1:0];
          sdx_r <= dx_s[SW-1];
          ady_r <= dy_abs[MW-1:0];
          sdy_r <= dy_s[SW-1];
          if (jit_c != '0) lcg_r <= lcg_r * hwt_pkg::LCG_MUL + hwt_pkg::LCG_INC;
        end
        S_SQ: begin
          dx2_r    <= (2*MW)'(adx_r) * (2*MW)'(adx_r);
          dy2_r    <= (2*MW)'(ady_r) * (2*MW)'(ady_r);
          dx2500_r <= SLEN'(adx_r) * SLEN'(hwt_pkg::SLOW_GAIN);
          dy2500_r <= SLEN'(ady_r) * SLEN'(hwt_pkg::SLOW_GAIN);
          rdraw_r  <= draw_prod[32 +: 7];
        end
        S_PREP: begin
          dsq_r  <= DVW'(dx2_r) + DVW'(dy2_r) + DVW'(1);
          prod_r <= sk_prod[PLEN-1:0];
          if (jit_c == '0) sp_r <= 10'(speed_c);
        end
        S_SPD: if (div_done) sp_r <= div_quot[9:0];
        S_NDX: if (div_done) adx_r <= div_quot[MW-1:0];
        S_NDY: if (div_done) ady_r <= div_quot[MW-1:0];
        S_MUL: begin
          qx_num_r <= QLEN'(ady_r) * QLEN'(sp_r);
          qy_num_r <= QLEN'(adx_r) * QLEN'(sp_r);
        end
        S_QX: begin
          // col = x + dy*sp/700, sign of the term is sign(dy) ^ reverse
          if (div_done) begin
            mx_r <= (sdy_r ^ rev_r) ?
                    $signed((SW+2)'(x_r)) - $signed((SW+2)'(q_s)) :
                    $signed((SW+2)'(x_r)) + $signed((SW+2)'(q_s));
          end
        end
        S_QY: begin
          // row = y - dx*sp/700
          if (div_done) begin
            my_r <= (sdx_r ^ rev_r) ?
                    $signed((SW+2)'(y_r)) + $signed((SW+2)'(q_s)) :
                    $signed((SW+2)'(y_r)) - $signed((SW+2)'(q_s));
          end
        end
        S_MX: begin
          if (div_done) begin
            col_r <= (mx_r[SW+1] && rem_w != '0) ? w_c - rem_w : rem_w;
          end
        end
        S_MY: begin
          if (div_done) begin
            row_r <= (my_r[SW+1] && rem_h != '0) ? h_c - rem_h : rem_h;
          end
        end
        S_IDX: begin
          if (out_free) begin
            out_word_r.source_index <= 20'(idx_full);
            out_word_r.source_col   <= 10'(col_r);
            out_word_r.source_row   <= 10'(row_r);
          end
        end
        default: ;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again right after accept");

  a_done_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_SPD || state_r == S_NDX || state_r == S_NDY ||
                  state_r == S_QX  || state_r == S_QY  ||
                  state_r == S_MX  || state_r == S_MY))
    else $error("divider finished outside a division step");

  a_wrapped_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDX) |-> (col_r < w_c && row_r < h_c))
    else $error("wrapped coordinate outside frame");

endmodule
